@@ src/tvf_pkg.sv @@
package tvf_pkg;

	localparam int unsigned DATA_W     = 32;
	localparam int unsigned LVL_W      = 8;
	localparam int unsigned STEP_W     = LVL_W + 1;
	localparam int unsigned MIN_W      = 16;
	localparam int unsigned MAXS_W     = 8;
	localparam int unsigned CFG_W      = 16;
	localparam int unsigned CNT_W      = $clog2(DATA_W);
	localparam int unsigned MAX_VOLUME = 255;
	localparam int unsigned MAX_DIVISOR = 1024;
	localparam int unsigned MIN_STEP_TIME_RESET = 100;
	localparam int unsigned MAX_STEPS_RESET     = 127;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_SET   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ACTIVE = 2'd1,
		PH_ENDED  = 2'd3
	} phase_t;

	typedef enum logic {
		REG_MIN_STEP_TIME = 1'b0,
		REG_MAX_STEPS     = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_T,
		ST_DIV_N,
		ST_DIV_S
	} seq_state_t;

	function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] x);
		logic [LVL_W-1:0] r;
		r = x;
		if (DATA_W'(x) > DATA_W'(MAX_VOLUME)) begin
			r = LVL_W'(MAX_VOLUME);
		end
		return r;
	endfunction

endpackage

@@ src/tvf_if.sv @@
interface tvf_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  op;
	logic [tvf_pkg::DATA_W-1:0]  now_ms;
	logic [tvf_pkg::DATA_W-1:0]  fade_ms;
	logic [tvf_pkg::LVL_W-1:0]   target_volume;
	logic                        power_on;
	logic                        restore;
	logic [tvf_pkg::LVL_W-1:0]   new_volume;

	modport source (
		output valid, op, now_ms, fade_ms, target_volume, power_on, restore, new_volume,
		input  ready
	);
	modport sink (
		input  valid, op, now_ms, fade_ms, target_volume, power_on, restore, new_volume,
		output ready
	);
endinterface

interface tvf_status_if;
	logic                       valid;
	logic                       ready;
	logic [tvf_pkg::LVL_W-1:0]  volume;
	logic                       fade_active;
	logic [1:0]                 fade_phase;

	modport source (
		output valid, volume, fade_active, fade_phase,
		input  ready
	);
	modport sink (
		input  valid, volume, fade_active, fade_phase,
		output ready
	);
endinterface

@@ src/timed_volume_fade.sv @@
// Tick, stop, set volume and starts that need no division give their result in the
// cycle after the request is taken; a start that opens a fade with a nonzero fade
// time runs two or three passes of one shared bit-serial divider.
// Throughput: one request at a time; the next request is taken once the result has gone.
// Reset (arst_n low, asynchronous): level, phase and fade state clear to zero, except
// the latched fade time and distance; min_step_time returns to 100, max_steps to 127.
module timed_volume_fade (
	input  logic                       clk,
	input  logic                       arst_n,
	tvf_cmd_if.sink                    cmd,
	tvf_status_if.source               status,
	input  logic                       wr_en,
	input  logic                       wr_index,
	input  logic [tvf_pkg::CFG_W-1:0]  wr_data
);

	localparam int unsigned DW = tvf_pkg::DATA_W;
	localparam int unsigned LW = tvf_pkg::LVL_W;
	localparam int unsigned SW = tvf_pkg::STEP_W;

	tvf_pkg::seq_state_t       state_q, state_d;
	tvf_pkg::phase_t           phase_q;
	logic [tvf_pkg::MIN_W-1:0]  min_step_q;
	logic [tvf_pkg::MAXS_W-1:0] max_steps_q;
	logic [LW-1:0]             cur_q, saved_q, goal_q;
	logic [DW-1:0]             interval_q, last_q, fade_q;
	logic signed [SW-1:0]      amount_q, dist_q;
	logic                      out_valid_q;

	logic                      cmd_acc;
	logic                      item_done;
	logic                      div_start, div_done;
	logic [DW-1:0]             div_dividend, div_divisor, div_quot;
	logic [LW-1:0]             tgt_c, nv_c, next_lvl;
	logic signed [SW-1:0]      dist_c, dist_now, s_c;
	logic [LW-1:0]             abs_dist;
	logic [DW-1:0]             n_eff, d_c;
	logic [SW-1:0]             mag, q9;
	logic [SW-1:0]             gap_up, gap_dn;
	logic                      tick_due;

	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == tvf_pkg::ST_IDLE) && (!out_valid_q || status.ready);

	assign tgt_c    = tvf_pkg::clamp_level(cmd.target_volume);
	assign nv_c     = tvf_pkg::clamp_level(cmd.new_volume);
	assign dist_c   = $signed({1'b0, tgt_c}) - $signed({1'b0, cur_q});
	assign dist_now = (state_q == tvf_pkg::ST_IDLE) ? dist_c : dist_q;
	assign abs_dist = dist_now[SW-1] ? LW'(-dist_now) : LW'(dist_now);
	assign n_eff    = (max_steps_q == '0) ? DW'(1) : DW'(max_steps_q);
	assign d_c      = (div_quot > DW'(tvf_pkg::MAX_DIVISOR)) ? DW'(tvf_pkg::MAX_DIVISOR)
	                                                        : div_quot;
	assign tick_due = (phase_q == tvf_pkg::PH_ACTIVE) && ((cmd.now_ms - last_q) > interval_q);

	always_comb begin
		q9 = div_quot[SW-1:0];
		s_c = dist_q[SW-1] ? -$signed(q9) : $signed(q9);
		if (s_c == '0) begin
			s_c = dist_q[SW-1] ? -SW'(1) : SW'(1);
		end
	end

	always_comb begin
		mag    = amount_q[SW-1] ? SW'(-amount_q) : SW'(amount_q);
		gap_up = {1'b0, goal_q} - {1'b0, cur_q};
		gap_dn = {1'b0, cur_q} - {1'b0, goal_q};
		next_lvl = cur_q;
		if (amount_q > 0) begin
			if (cur_q < goal_q && mag < gap_up) begin
				next_lvl = cur_q + mag[LW-1:0];
			end else begin
				next_lvl = goal_q;
			end
		end else if (amount_q < 0) begin
			if (cur_q > goal_q && mag < gap_dn) begin
				next_lvl = cur_q - mag[LW-1:0];
			end else begin
				next_lvl = goal_q;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = fade_q;
		div_divisor  = n_eff;
		item_done    = 1'b0;
		case (state_q)
			tvf_pkg::ST_IDLE: begin
				if (cmd_acc) begin
					if (tvf_pkg::op_t'(cmd.op) == tvf_pkg::OP_START && cmd.power_on
					    && dist_c != '0 && cmd.fade_ms != '0) begin
						div_start    = 1'b1;
						div_dividend = cmd.fade_ms;
						div_divisor  = n_eff;
						state_d      = tvf_pkg::ST_DIV_T;
					end else begin
						item_done = 1'b1;
					end
				end
			end
			tvf_pkg::ST_DIV_T: begin
				if (div_done) begin
					div_start = 1'b1;
					if (div_quot < DW'(min_step_q)) begin
						div_dividend = fade_q;
						div_divisor  = DW'(min_step_q);
						state_d      = tvf_pkg::ST_DIV_N;
					end else begin
						div_dividend = DW'(abs_dist);
						div_divisor  = n_eff;
						state_d      = tvf_pkg::ST_DIV_S;
					end
				end
			end
			tvf_pkg::ST_DIV_N: begin
				if (div_done) begin
					if (div_quot == '0) begin
						item_done = 1'b1;
						state_d   = tvf_pkg::ST_IDLE;
					end else begin
						div_start    = 1'b1;
						div_dividend = DW'(abs_dist);
						div_divisor  = d_c;
						state_d      = tvf_pkg::ST_DIV_S;
					end
				end
			end
			tvf_pkg::ST_DIV_S: begin
				if (div_done) begin
					item_done = 1'b1;
					state_d   = tvf_pkg::ST_IDLE;
				end
			end
			default: state_d = tvf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tvf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_step_q  <= tvf_pkg::MIN_W'(tvf_pkg::MIN_STEP_TIME_RESET);
			max_steps_q <= tvf_pkg::MAXS_W'(tvf_pkg::MAX_STEPS_RESET);
		end else if (wr_en) begin
			case (tvf_pkg::reg_idx_t'(wr_index))
				tvf_pkg::REG_MIN_STEP_TIME: min_step_q  <= wr_data[tvf_pkg::MIN_W-1:0];
				tvf_pkg::REG_MAX_STEPS:     max_steps_q <= wr_data[tvf_pkg::MAXS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_done) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= tvf_pkg::PH_IDLE;
			cur_q      <= '0;
			saved_q    <= '0;
			goal_q     <= '0;
			interval_q <= '0;
			amount_q   <= '0;
			last_q     <= '0;
		end else begin
			case (state_q)
				tvf_pkg::ST_IDLE: begin
					if (cmd_acc) begin
						case (tvf_pkg::op_t'(cmd.op))
							tvf_pkg::OP_TICK: begin
								if (tick_due) begin
									last_q <= cmd.now_ms;
									if (cur_q == goal_q) begin
										phase_q <= tvf_pkg::PH_ENDED;
									end else begin
										cur_q <= next_lvl;
									end
								end
							end
							tvf_pkg::OP_START: begin
								phase_q <= tvf_pkg::PH_IDLE;
								if (cmd.power_on) begin
									saved_q <= cur_q;
									if (dist_c != '0) begin
										goal_q  <= tgt_c;
										phase_q <= tvf_pkg::PH_ACTIVE;
										last_q  <= cmd.now_ms;
										if (cmd.fade_ms == '0) begin
											interval_q <= '0;
											amount_q   <= dist_c;
										end
									end
								end
							end
							tvf_pkg::OP_STOP: begin
								if (phase_q != tvf_pkg::PH_IDLE) begin
									if (cmd.restore) begin
										cur_q <= saved_q;
									end
									phase_q <= tvf_pkg::PH_IDLE;
								end
							end
							tvf_pkg::OP_SET: cur_q <= nv_c;
							default: ;
						endcase
					end
				end
				tvf_pkg::ST_DIV_T: begin
					if (div_done) begin
						if (div_quot < DW'(min_step_q)) begin
							interval_q <= DW'(min_step_q);
						end else begin
							interval_q <= div_quot;
						end
					end
				end
				tvf_pkg::ST_DIV_N: begin
					if (div_done && div_quot == '0) begin
						amount_q <= dist_q;
					end
				end
				tvf_pkg::ST_DIV_S: begin
					if (div_done) begin
						amount_q <= s_c;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			fade_q <= cmd.fade_ms;
			dist_q <= dist_c;
		end
	end

	tvf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign status.valid       = out_valid_q;
	assign status.volume      = cur_q;
	assign status.fade_active = (phase_q == tvf_pkg::PH_ACTIVE);
	assign status.fade_phase  = phase_q;

endmodule

@@ src/tvf_div.sv @@
module tvf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tvf_pkg::DATA_W-1:0] dividend,
	input  logic [tvf_pkg::DATA_W-1:0] divisor,
	output logic                       done,
	output logic [tvf_pkg::DATA_W-1:0] quotient
);

	logic                         busy_q;
	logic                         done_q;
	logic [tvf_pkg::CNT_W-1:0]    cnt_q;
	logic [tvf_pkg::DATA_W-1:0]   rem_q;
	logic [tvf_pkg::DATA_W-1:0]   quo_q;
	logic [tvf_pkg::DATA_W-1:0]   dsr_q;
	logic [tvf_pkg::DATA_W:0]     trial;
	logic [tvf_pkg::DATA_W:0]     diff;

	assign trial = {rem_q, quo_q[tvf_pkg::DATA_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == tvf_pkg::CNT_W'(tvf_pkg::DATA_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[tvf_pkg::DATA_W]) begin
				rem_q <= diff[tvf_pkg::DATA_W-1:0];
				quo_q <= {quo_q[tvf_pkg::DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[tvf_pkg::DATA_W-1:0];
				quo_q <= {quo_q[tvf_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ src/tvf_checker.sv @@
module tvf_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cmd_valid,
	input logic                      cmd_ready,
	input logic [1:0]                cmd_op,
	input logic [tvf_pkg::LVL_W-1:0] cmd_new_volume,
	input logic                      st_valid,
	input logic                      st_ready,
	input logic [tvf_pkg::LVL_W-1:0] st_volume,
	input logic                      st_active,
	input logic [1:0]                st_phase
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		st_valid && !st_ready |=> st_valid && $stable(st_volume))
		else $error("Stalled result changed or vanished.");

	a_active: assert property (@(posedge clk) disable iff (!arst_n)
		st_valid |-> (st_active == (st_phase == tvf_pkg::PH_ACTIVE)))
		else $error("Active flag disagrees with the phase.");

	a_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_op == tvf_pkg::OP_SET |=>
		st_valid && st_volume == tvf_pkg::clamp_level($past(cmd_new_volume)))
		else $error("Set volume request not reflected in the next result.");

	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_op == tvf_pkg::OP_STOP |=>
		st_valid && st_phase == tvf_pkg::PH_IDLE)
		else $error("Stop request did not leave the fader idle.");

endmodule

bind timed_volume_fade tvf_checker u_tvf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.cmd_op         (cmd.op),
	.cmd_new_volume (cmd.new_volume),
	.st_valid       (status.valid),
	.st_ready       (status.ready),
	.st_volume      (status.volume),
	.st_active      (status.fade_active),
	.st_phase       (status.fade_phase)
);

@@ tb/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tvf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned ITEMS_PER_SETTING = 215;

	typedef struct packed {
		op_t                op;
		logic [DATA_W-1:0]  now_ms;
		logic [DATA_W-1:0]  fade_ms;
		logic [LVL_W-1:0]   target_volume;
		logic               power_on;
		logic               restore;
		logic [LVL_W-1:0]   new_volume;
	} fade_request_t;

	typedef struct packed {
		logic [LVL_W-1:0]  volume;
		logic              fade_active;
		phase_t            fade_phase;
	} fade_status_t;

	typedef struct packed {
		fade_request_t  req;
		logic           pinned;
		fade_status_t   want;
	} fade_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              wr_en;
	logic              wr_index;
	logic [CFG_W-1:0]  wr_data;

	tvf_cmd_if    cmd_bus ();
	tvf_status_if status_bus ();

	timed_volume_fade dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_bus),
		.status   (status_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Shadow copy of the fader: registers and fade state.
	logic [MIN_W-1:0]   cfg_min_gap;
	logic [MAXS_W-1:0]  cfg_max_steps;
	phase_t             fader_phase;
	logic [LVL_W-1:0]   level_now;
	logic [LVL_W-1:0]   level_saved;
	logic [LVL_W-1:0]   level_goal;
	logic [DATA_W-1:0]  step_gap;
	logic signed [STEP_W-1:0] step_delta;
	logic [DATA_W-1:0]  last_step_ms;

	fade_status_t  expected_status [$];
	fade_status_t  want;
	int unsigned   mismatch_count;
	int unsigned   requests_sent;
	int unsigned   cycle_count;
	logic [DATA_W-1:0] clock_ms;
	logic          steady_flow;

	fade_row_t directed_rows [22] = '{
		'{'{OP_TICK, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0, 8'd0}, 1'b1, '{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_SET, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0, 8'd255}, 1'b1, '{8'd255, 1'b0, PH_IDLE}},
		'{'{OP_SET, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0, 8'd0}, 1'b1, '{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_START, 32'd5, 32'd1000, 8'd200, 1'b0, 1'b0, 8'd0}, 1'b1, '{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_START, 32'd6, 32'd1000, 8'd0, 1'b1, 1'b0, 8'd0}, 1'b1, '{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_START, 32'd1000, 32'd0, 8'd255, 1'b1, 1'b0, 8'd0}, 1'b1,
			'{8'd0, 1'b1, PH_ACTIVE}},
		'{'{OP_TICK, 32'd1000, 32'd0, 8'd0, 1'b0, 1'b0, 8'd0}, 1'b1, '{8'd0, 1'b1, PH_ACTIVE}},
		'{'{OP_TICK, 32'd1001, 32'd0, 8'd0, 1'b0, 1'b0, 8'd0}, 1'b1,
			'{8'd255, 1'b1, PH_ACTIVE}},
		'{'{OP_TICK, 32'd1002, 32'd0, 8'd0, 1'b0, 1'b0, 8'd0}, 1'b1,
			'{8'd255, 1'b0, PH_ENDED}},
		'{'{OP_STOP, 32'd0, 32'd0, 8'd0, 1'b0, 1'b1, 8'd0}, 1'b1, '{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_STOP, 32'd0, 32'd0, 8'd0, 1'b0, 1'b1, 8'd0}, 1'b1, '{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_START, 32'hFFFF_FFF0, 32'd1000, 8'd200, 1'b1, 1'b0, 8'd0}, 1'b0,
			'{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_TICK, 32'h0000_0060, 32'd0, 8'd0, 1'b0, 1'b0, 8'd0}, 1'b0,
			'{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_SET, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0, 8'd250}, 1'b0, '{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_TICK, 32'h0000_00D0, 32'd0, 8'd0, 1'b0, 1'b0, 8'd0}, 1'b0,
			'{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_START, 32'h0000_0100, 32'hFFFF_FFFF, 8'd10, 1'b1, 1'b0, 8'd0}, 1'b0,
			'{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_TICK, 32'hFFFF_FFFF, 32'd0, 8'd0, 1'b0, 1'b0, 8'd0}, 1'b0,
			'{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_STOP, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0, 8'd0}, 1'b0, '{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_START, 32'd0, 32'd50, 8'd255, 1'b1, 1'b0, 8'd0}, 1'b0, '{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_TICK, 32'd101, 32'd0, 8'd0, 1'b0, 1'b0, 8'd0}, 1'b0, '{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_TICK, 32'd202, 32'd0, 8'd0, 1'b0, 1'b0, 8'd0}, 1'b0, '{8'd0, 1'b0, PH_IDLE}},
		'{'{OP_STOP, 32'd0, 32'd0, 8'd0, 1'b0, 1'b1, 8'd0}, 1'b0, '{8'd0, 1'b0, PH_IDLE}}
	};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void plan_ramp(input logic [DATA_W-1:0] fade,
			input logic [LVL_W-1:0] from, input logic [LVL_W-1:0] to);
		int span;
		int unsigned n;
		int unsigned t;
		int s;
		span = int'(to) - int'(from);
		n = (cfg_max_steps != 0) ? int'(cfg_max_steps) : 1;
		if (fade == 0) begin
			step_gap = '0;
			step_delta = STEP_W'(span);
			return;
		end
		t = fade / n;
		if (t < cfg_min_gap) begin
			t = cfg_min_gap;
			n = fade / t;
		end
		if (n > 0) begin
			s = span / int'((n > MAX_DIVISOR) ? MAX_DIVISOR : n);
		end else begin
			s = span;
		end
		if (s == 0) begin
			s = (span > 0) ? 1 : -1;
		end
		step_gap = t;
		step_delta = STEP_W'(s);
	endfunction

	function automatic logic [LVL_W-1:0] stepped_level();
		int cur;
		int goal;
		int s;
		cur = level_now;
		goal = level_goal;
		s = step_delta;
		if (s > 0) begin
			return (cur < goal && s < goal - cur) ? LVL_W'(cur + s) : level_goal;
		end
		if (s < 0) begin
			return (cur > goal && -s < cur - goal) ? LVL_W'(cur + s) : level_goal;
		end
		return level_now;
	endfunction

	function automatic fade_status_t predict_status(input fade_request_t r);
		case (r.op)
			OP_TICK: begin
				if (fader_phase == PH_ACTIVE && (r.now_ms - last_step_ms) > step_gap) begin
					last_step_ms = r.now_ms;
					if (level_now == level_goal) begin
						fader_phase = PH_ENDED;
					end else begin
						level_now = stepped_level();
					end
				end
			end
			OP_START: begin
				fader_phase = PH_IDLE;
				if (r.power_on) begin
					level_saved = level_now;
					if (level_saved != r.target_volume) begin
						plan_ramp(r.fade_ms, level_saved, r.target_volume);
						level_goal = r.target_volume;
						fader_phase = PH_ACTIVE;
						last_step_ms = r.now_ms;
					end
				end
			end
			OP_STOP: begin
				if (fader_phase != PH_IDLE) begin
					if (r.restore) begin
						level_now = level_saved;
					end
					fader_phase = PH_IDLE;
				end
			end
			default: begin
				level_now = r.new_volume;
			end
		endcase
		return '{level_now, fader_phase == PH_ACTIVE, fader_phase};
	endfunction

	function automatic fade_request_t random_request();
		fade_request_t r;
		r.op = op_t'($urandom_range(3));
		r.now_ms = $urandom;
		r.fade_ms = $urandom;
		r.target_volume = LVL_W'($urandom_range(255));
		r.power_on = 1'($urandom_range(1));
		r.restore = 1'($urandom_range(1));
		r.new_volume = LVL_W'($urandom_range(255));
		return r;
	endfunction

	task automatic send_request(input fade_request_t r, input logic pinned,
			input fade_status_t pinned_status);
		fade_status_t predicted;
		while (!steady_flow && $urandom_range(99) < 12) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.op <= r.op;
		cmd_bus.now_ms <= r.now_ms;
		cmd_bus.fade_ms <= r.fade_ms;
		cmd_bus.target_volume <= r.target_volume;
		cmd_bus.power_on <= r.power_on;
		cmd_bus.restore <= r.restore;
		cmd_bus.new_volume <= r.new_volume;
		do @(posedge clk); while (!cmd_bus.ready);
		predicted = predict_status(r);
		expected_status.push_back(pinned ? pinned_status : predicted);
		requests_sent++;
	endtask

	task automatic drain();
		cmd_bus.valid <= 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
	endtask

	task automatic program_registers(input logic [MIN_W-1:0] min_gap,
			input logic [MAXS_W-1:0] max_steps);
		wr_en <= 1'b1;
		wr_index <= REG_MIN_STEP_TIME;
		wr_data <= CFG_W'(min_gap);
		@(posedge clk);
		wr_index <= REG_MAX_STEPS;
		wr_data <= CFG_W'(max_steps);
		@(posedge clk);
		wr_en <= 1'b0;
		cfg_min_gap = min_gap;
		cfg_max_steps = max_steps;
	endtask

	// Mostly whole fades: a start, then ticks paced on the step interval until the
	// fade ends or a cap is hit, with the odd set, stop or restart; rest is noise.
	task automatic run_random(input int unsigned count);
		fade_request_t r;
		int unsigned goal_count;
		int unsigned tick_cap;
		int unsigned ticks;
		goal_count = requests_sent + count;
		while (requests_sent < goal_count) begin
			r = random_request();
			if ($urandom_range(99) < 12) begin
				send_request(r, 1'b0, '0);
			end else begin
				r.op = OP_START;
				r.power_on = ($urandom_range(9) != 0);
				clock_ms += DATA_W'($urandom_range(50));
				r.now_ms = clock_ms;
				case ($urandom_range(9))
					0: r.fade_ms = '0;
					1: r.fade_ms = $urandom;
					2, 3, 4: r.fade_ms = $urandom_range(300);
					default: r.fade_ms = $urandom_range(20000);
				endcase
				send_request(r, 1'b0, '0);
				tick_cap = $urandom_range(2, 300);
				ticks = 0;
				while (ticks < tick_cap && requests_sent < goal_count
						&& (fader_phase == PH_ACTIVE || ticks < 2)) begin
					r = random_request();
					case ($urandom_range(19))
						0: r.op = OP_SET;
						1: r.op = OP_STOP;
						2: begin
							r.op = OP_START;
							r.now_ms = clock_ms;
							r.fade_ms = $urandom_range(5000);
						end
						3, 4, 5: begin
							r.op = OP_TICK;
							clock_ms += DATA_W'($urandom_range(step_gap));
							r.now_ms = clock_ms;
						end
						default: begin
							r.op = OP_TICK;
							clock_ms += step_gap + DATA_W'($urandom_range(1, 3));
							r.now_ms = clock_ms;
						end
					endcase
					send_request(r, 1'b0, '0);
					ticks++;
				end
				if ($urandom_range(1) == 1) begin
					r = random_request();
					r.op = OP_STOP;
					send_request(r, 1'b0, '0);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && status_bus.valid && status_bus.ready) begin
			if (expected_status.size() == 0) begin
				$display("%0t: status with no request waiting: volume %0d active %0b phase %0d",
					$realtime, status_bus.volume, status_bus.fade_active,
					status_bus.fade_phase);
				mismatch_count++;
			end else begin
				want = expected_status.pop_front();
				if (status_bus.volume !== want.volume
						|| status_bus.fade_active !== want.fade_active
						|| status_bus.fade_phase !== want.fade_phase) begin
					$display("%0t: expected volume %0d active %0b phase %0d, got %0d %0b %0d",
						$realtime, want.volume, want.fade_active, want.fade_phase,
						status_bus.volume, status_bus.fade_active, status_bus.fade_phase);
					mismatch_count++;
				end
			end
		end
		status_bus.ready <= steady_flow || ($urandom_range(99) >= 12);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[timed_volume_fade] ERROR");
			$finish;
		end
	end

	initial begin
		logic [MIN_W-1:0] gap_setting [5];
		logic [MAXS_W-1:0] steps_setting [5];
		logic [MIN_W-1:0] min_v;
		logic [MAXS_W-1:0] max_v;
		gap_setting = '{16'd1, 16'd65535, 16'd0, 16'd0, 16'd100};
		steps_setting = '{8'd255, 8'd1, 8'd0, 8'd0, 8'd127};
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_MIN_STEP_TIME;
		wr_data = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.op = OP_TICK;
		cmd_bus.now_ms = '0;
		cmd_bus.fade_ms = '0;
		cmd_bus.target_volume = '0;
		cmd_bus.power_on = 1'b0;
		cmd_bus.restore = 1'b0;
		cmd_bus.new_volume = '0;
		status_bus.ready = 1'b0;
		steady_flow = 1'b0;
		cycle_count = 0;
		mismatch_count = 0;
		requests_sent = 0;
		clock_ms = '0;
		cfg_min_gap = MIN_W'(MIN_STEP_TIME_RESET);
		cfg_max_steps = MAXS_W'(MAX_STEPS_RESET);
		fader_phase = PH_IDLE;
		level_now = '0;
		level_saved = '0;
		level_goal = '0;
		step_gap = '0;
		step_delta = '0;
		last_step_ms = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].want);
		end

		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				drain();
				min_v = gap_setting[p-1];
				max_v = steps_setting[p-1];
				if (p == 4) begin
					min_v = MIN_W'($urandom_range(1, 400));
					max_v = MAXS_W'($urandom_range(1, 255));
				end
				program_registers(min_v, max_v);
			end
			steady_flow <= (p == 2);
			run_random(ITEMS_PER_SETTING);
		end

		drain();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && expected_status.size() == 0) begin
			$display("[timed_volume_fade] OK");
		end else begin
			$display("[timed_volume_fade] ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/tvf_pkg.sv
src/tvf_if.sv
src/tvf_div.sv
src/timed_volume_fade.sv
src/tvf_checker.sv
tb/testbench.sv
